/* rtl/core/modular_exponentiation_top_macros.svh */
// Assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset
`define MODEXP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define MODEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/modexp_pkg.sv */
// Shared widths and types for the modular exponentiation block
package modexp_pkg;
  localparam int FieldBits = 54;
  localparam int CntBits = $clog2(FieldBits + 1);
  typedef logic [FieldBits-1:0] word_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef struct packed {
    logic load;
    logic dbl;
    logic add;
  } cell_ctl_t;
endpackage

/* rtl/core/modexp_cell.sv */
// One bit slice of the shift-and-add modular multiplier accumulator
module modexp_cell (
  input  logic clk,
  input  modexp_pkg::cell_ctl_t ctl,
  input  logic acc_in,
  input  logic x_bit,
  input  logic m_bit,
  input  logic sub_sel,
  input  logic cin_a,
  input  logic bin_b,
  output logic acc_out,
  output logic cout_a,
  output logic bout_b
);
  import modexp_pkg::*;
  logic acc;
  logic s;
  logic d;
  logic res_bit;
  assign acc_out = acc;
  assign s = acc_in ^ (x_bit & ctl.add) ^ cin_a;
  assign cout_a = (acc_in & (x_bit & ctl.add)) | (cin_a & (acc_in ^ (x_bit & ctl.add)));
  assign d = s ^ m_bit ^ bin_b;
  assign bout_b = (~s & m_bit) | (~(s ^ m_bit) & bin_b);
  assign res_bit = sub_sel ? d : s;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= 1'b0;
    end else if (ctl.dbl) begin
      acc <= res_bit;
    end
  end
endmodule

/* rtl/core/modexp_mulmod.sv */
// Chain of cells computing x*y mod m one multiplier bit at a time, from the top bit down
module modexp_mulmod (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  modexp_pkg::word_t x,
  input  modexp_pkg::word_t y,
  input  modexp_pkg::word_t m,
  output logic done,
  output modexp_pkg::word_t prod
);
  import modexp_pkg::*;
  localparam int W = FieldBits + 2;
  typedef enum logic [1:0] {S_IDLE, S_DBL, S_ADD} st_t;
  st_t st;
  cnt_t idx;
  word_t yr;
  logic [W-1:0] accv;
  logic [W-1:0] opx;
  logic [W-1:0] mv;
  logic [W:0] ca;
  logic [W:0] bb;
  logic [W-1:0] shl;
  logic [W-1:0] inv;
  logic sub_sel;
  cell_ctl_t ctl;
  assign shl = {accv[W-2:0], 1'b0};
  assign inv = (st == S_DBL) ? shl : accv;
  assign opx = (st == S_DBL) ? shl : {2'b00, x};
  assign mv = {2'b00, m};
  assign ca[0] = 1'b0;
  assign bb[0] = 1'b0;
  assign ctl.load = (st == S_IDLE) & go;
  assign ctl.dbl = (st == S_DBL) | (st == S_ADD);
  assign ctl.add = (st == S_ADD);
  // sum below 2m: subtract when no final borrow out
  assign sub_sel = ~bb[W];
  for (genvar i = 0; i < W; i++) begin : g_cell
    modexp_cell u_cell (
      .clk(clk), .ctl(ctl), .acc_in(inv[i]), .x_bit(opx[i]), .m_bit(mv[i]),
      .sub_sel(sub_sel), .cin_a(ca[i]), .bin_b(bb[i]), .acc_out(accv[i]),
      .cout_a(ca[i+1]), .bout_b(bb[i+1])
    );
  end
  assign prod = accv[FieldBits-1:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (go) begin
            st <= S_DBL;
            yr <= y;
            idx <= cnt_t'(FieldBits - 1);
          end
        end
        S_DBL: begin
          if (yr[idx[CntBits-1:0]]) begin
            st <= S_ADD;
          end else if (idx == '0) begin
            st <= S_IDLE;
            done <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_ADD: begin
          if (idx == '0) begin
            st <= S_IDLE;
            done <= 1'b1;
          end else begin
            st <= S_DBL;
            idx <= idx - 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/modexp_reduce.sv */
// Bit-serial restoring reduction of the base modulo the modulus
module modexp_reduce (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  modexp_pkg::word_t b,
  input  modexp_pkg::word_t m,
  output logic done,
  output modexp_pkg::word_t rem
);
  import modexp_pkg::*;
  logic busy_r;
  cnt_t idx;
  word_t br;
  logic [FieldBits:0] sh;
  logic [FieldBits:0] df;
  assign sh = {rem, br[idx[CntBits-1:0]]};
  assign df = sh - {1'b0, m};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      if (!busy_r) begin
        if (go) begin
          busy_r <= 1'b1;
          br <= b;
          rem <= '0;
          idx <= cnt_t'(FieldBits - 1);
        end
      end else begin
        rem <= df[FieldBits] ? sh[FieldBits-1:0] : df[FieldBits-1:0];
        if (idx == '0) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/core/modular_exponentiation_top.sv */
// Top level: right-to-left square-and-multiply modular exponentiation
//  channel  | ports                          | handshake
//  command  | start, base, exponent, modulus | accepted when start && !busy
//  result   | done, power_residue            | one-cycle strobe, no stall
// One item at a time; busy stays high from acceptance to the result strobe.
// Base reduction runs bit-serially; each multiplication doubles per multiplier bit and adds per set bit.
// Each exponent bit up to the top set bit costs up to two multiplications.
// An exponent of zero skips reduction and goes straight to the finish state.
// Synchronous reset clears control; the receiver cannot stall results.
module modular_exponentiation_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  modexp_pkg::word_t base,
  input  modexp_pkg::word_t exponent,
  input  modexp_pkg::word_t modulus,
  output logic done,
  output modexp_pkg::word_t power_residue
);
  import modexp_pkg::*;
  `include "modular_exponentiation_top_macros.svh"
  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_SQ, S_FIN} st_t;
  st_t st;
  word_t e;
  word_t m;
  word_t acc;
  word_t sq;
  logic red_go;
  logic red_done;
  word_t red_rem;
  logic mul_go;
  logic mul_done;
  word_t mul_x;
  word_t mul_y;
  word_t mul_p;
  modexp_reduce u_red (
    .clk(clk), .rst(rst), .go(red_go), .b(base), .m(m),
    .done(red_done), .rem(red_rem)
  );
  modexp_mulmod u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .x(mul_x), .y(mul_y), .m(m),
    .done(mul_done), .prod(mul_p)
  );
  assign red_go = (st == S_IDLE) & start & (exponent != '0) & (modulus > word_t'(1));
  assign mul_x = (st == S_MUL) ? acc : sq;
  assign mul_y = sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      done <= 1'b0;
      mul_go <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            e <= exponent;
            m <= modulus;
            acc <= word_t'(1);
            if (exponent == '0) begin
              power_residue <= word_t'(1);
              st <= S_FIN;
            end else if (modulus <= word_t'(1)) begin
              power_residue <= '0;
              st <= S_FIN;
            end else begin
              st <= S_RED;
            end
          end
        end
        S_RED: begin
          if (red_done) begin
            sq <= red_rem;
            mul_go <= 1'b1;
            st <= e[0] ? S_MUL : S_SQ;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            acc <= mul_p;
            mul_go <= 1'b1;
            st <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            sq <= mul_p;
            if (e[FieldBits-1:1] == '0) begin
              power_residue <= acc;
              st <= S_FIN;
            end else begin
              e <= e >> 1;
              mul_go <= 1'b1;
              st <= e[1] ? S_MUL : S_SQ;
            end
          end
        end
        S_FIN: begin
          done <= 1'b1;
          busy <= 1'b0;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
  `MODEXP_ASSERT_IMPL(a_done_ends_busy, done, !busy, "busy held after result")
  `MODEXP_ASSERT_IMPL(a_done_from_fin, done, $past(st == S_FIN), "result without finish")
  `MODEXP_ASSERT_IMPL(a_no_start_mid, busy && !done, st != S_IDLE, "busy while idle")
  `MODEXP_ASSERT_IMPL(a_sq_below_m, st == S_SQ || st == S_MUL, sq < m, "square not reduced")
endmodule

/* test/modular_exponentiation_top_test.sv */
// Testbench for the square-and-multiply modular exponentiation block
module modular_exponentiation_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import modexp_pkg::*;

  localparam int StallLimit = 100000;
  localparam logic [FieldBits-1:0] FieldMax = '1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  word_t base;
  word_t exponent;
  word_t modulus;
  logic done;
  word_t power_residue;

  word_t residues_due[$];
  int errors;
  int transfers;
  int results_seen;
  int idle_cycles;
  int sender_delay;

  modular_exponentiation_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base(base),
    .exponent(exponent),
    .modulus(modulus),
    .done(done),
    .power_residue(power_residue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t mod_product(word_t x, word_t y, word_t m);
    logic [FieldBits:0] acc;
    acc = '0;
    for (int i = FieldBits - 1; i >= 0; i--) begin
      acc = acc + acc;
      if (acc >= m) acc = acc - m;
      if (y[i]) begin
        acc = acc + x;
        if (acc >= m) acc = acc - m;
      end
    end
    return acc[FieldBits-1:0];
  endfunction

  function automatic word_t power_mod(word_t b, word_t e, word_t m);
    word_t acc;
    word_t sq;
    if (e == '0) return word_t'(1);
    if (m <= word_t'(1)) return '0;
    acc = word_t'(1);
    sq = b % m;
    while (e != '0) begin
      if (e[0]) acc = mod_product(acc, sq, m);
      sq = mod_product(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic word_t random_word();
    return word_t'({$urandom, $urandom});
  endfunction

  task automatic send_item(word_t b, word_t e, word_t m);
    sender_delay = $urandom_range(0, 15);
    @(negedge clk);
    if (sender_delay != 0) begin
      start <= 1'b0;
      repeat (sender_delay) @(negedge clk);
    end
    base <= b;
    exponent <= e;
    modulus <= m;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    residues_due.push_back(power_mod(b, e, m));
    transfers++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (residues_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_extremes();
    send_item('0, '0, '0);
    send_item(FieldMax, '0, word_t'(1));
    send_item(FieldMax, FieldMax, FieldMax);
    send_item(FieldMax, FieldMax, word_t'(1));
    send_item(word_t'(5), FieldMax, '0);
    send_item('0, word_t'(3), word_t'(7));
    send_item(word_t'(1), FieldMax, 54'd9999999999999999);
    send_item(54'd9999999999999999, 54'd9999999999999999,
              54'd9999999999999999);
    send_item(word_t'(2), word_t'(10), word_t'(1000));
    send_item(word_t'(3), word_t'(1), word_t'(2));
  endtask

  task automatic test_base_above_modulus();
    send_item(word_t'(1000), word_t'(7), word_t'(13));
    send_item(FieldMax, word_t'(2), 54'd9999999967);
    send_item(54'd9999999999999999, word_t'(65537), word_t'(999983));
    send_item(word_t'(42), word_t'(1), word_t'(42));
  endtask

  task automatic test_quiet_sender();
    drain();
    send_item(random_word(), random_word(), random_word());
    drain();
  endtask

  task automatic test_random();
    word_t b;
    word_t e;
    word_t m;
    for (int n = 0; n < 90; n++) begin
      b = random_word();
      e = random_word();
      m = random_word();
      case ($urandom_range(0, 9))
        0: e = '0;
        1: m = word_t'($urandom_range(0, 1));
        2: e = e >> $urandom_range(40, 53);
        3: m = m >> $urandom_range(0, 50);
        4: b = b >> $urandom_range(0, 53);
        default: ;
      endcase
      send_item(b, e, m);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (residues_due.size() == 0) begin
        $display("%0t: result %0d with nothing pending", $time, power_residue);
        errors++;
      end else begin
        if (power_residue !== residues_due[0]) begin
          $display("%0t: power_residue expected %0d actual %0d", $time,
                   residues_due[0], power_residue);
          errors++;
        end
        void'(residues_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    transfers = 0;
    results_seen = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    base = '0;
    exponent = '0;
    modulus = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_base_above_modulus();
    test_quiet_sender();
    test_random();
    drain();
    $display("Covered %0d transfers and %0d results: extremes, zero and unit moduli,",
             transfers, results_seen);
    $display("bases above the modulus, an idle gap and random operands.");
    if (errors == 0 && residues_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
